### rtl/core/cc20_pkg.sv
// shared types, constants and state helpers for the chacha20 stream core
package cc20_pkg;

  typedef logic [15:0][31:0] cc20_words_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cc20_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cc20_sts_t;

  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_NONCE_01 = 3'd4;
  localparam logic [2:0] REG_NONCE_2  = 3'd5;
  localparam logic [2:0] REG_INIT_CTR = 3'd6;

  localparam logic [1:0] STEP_AB16 = 2'd0;
  localparam logic [1:0] STEP_CD12 = 2'd1;
  localparam logic [1:0] STEP_AB8  = 2'd2;
  localparam logic [1:0] STEP_CD7  = 2'd3;

  localparam logic [1:0] PERM_ROT1      = 2'd0;
  localparam logic [1:0] PERM_TO_DIAG   = 2'd1;
  localparam logic [1:0] PERM_FROM_DIAG = 2'd2;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // input state word: sigma, key, counter, nonce
  function automatic logic [31:0] init_word(cc20_cfg_t cfg, logic [31:0] ctr,
                                            logic [3:0] idx);
    logic [31:0] w;
    logic [3:0]  k;
    logic [3:0]  n;
    k = idx - 4'd4;
    n = idx - 4'd13;
    priority if (idx < 4'd4) begin
      w = SIGMA[idx[1:0]];
    end else if (idx < 4'd12) begin
      w = cfg.key[k[2:0]];
    end else if (idx == 4'd12) begin
      w = ctr;
    end else begin
      w = cfg.nonce[n[1:0]];
    end
    return w;
  endfunction

  function automatic cc20_words_t init_state(cc20_cfg_t cfg, logic [31:0] ctr);
    cc20_words_t w;
    for (int i = 0; i < 16; i++) begin
      w[i] = init_word(cfg, ctr, 4'(i));
    end
    return w;
  endfunction

  // rotate each row of four words left, amount per row set by kind
  function automatic cc20_words_t permute_rows(cc20_words_t w, logic [1:0] kind);
    cc20_words_t o;
    int amt;
    for (int r = 0; r < 4; r++) begin
      unique case (kind)
        PERM_TO_DIAG:   amt = 1 + r;
        PERM_FROM_DIAG: amt = 5 - r;
        default:        amt = 1;
      endcase
      for (int c = 0; c < 4; c++) begin
        o[r * 4 + c] = w[r * 4 + ((c + amt) % 4)];
      end
    end
    return o;
  endfunction

endpackage

### rtl/core/chacha20_ietf_stream_xor.sv
// chacha20 (ietf) byte stream xor, top level
//
//   channel  dir  fields (low bit up)                 handshake
//   s_axis   in   tdata: msg_byte; tuser: first_byte;  tvalid/tready
//                 tlast: last_byte
//   m_axis   out  tdata: result_byte; tlast: result_last tvalid/tready
//   cfg      in   cfg_idx_i register, cfg_wdata_i       cfg_we_i
//
// a byte that opens a 64-byte block waits for the block to be computed:
// 32 quarter-round steps per double round and 16 feed-forward adds, all
// through one adder/rotator; other bytes go straight into the output register
// reset clears control state and the key, nonce and counter registers only, no clearing pass
// the output register holds a result until taken; input waits meanwhile
module chacha20_ietf_stream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // result_byte
  output logic        m_axis_tlast    // result_last
);

  logic [7:0][31:0]      key_q;
  logic [2:0][31:0]      nonce_q;
  logic [31:0]           init_ctr_q;
  logic [31:0]           blk_ctr_q;
  logic [5:0]            off_q;
  logic                  pend_q;
  logic [7:0]            pend_msg_q;
  logic                  pend_last_q;
  logic                  m_valid_q;
  logic [7:0]            m_data_q;
  logic                  m_last_q;

  cc20_pkg::cc20_cfg_t   cfg;
  cc20_pkg::cc20_sts_t   sts;
  cc20_pkg::cc20_words_t ks_words;

  logic                  in_acc, out_acc, need_blk, start;
  logic [31:0]           ctr_eff;
  logic [5:0]            off_eff;
  logic [7:0]            ks_byte;

  assign cfg.key   = key_q;
  assign cfg.nonce = nonce_q;

  cc20_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .ctr_i  (ctr_eff),
    .cfg_i  (cfg),
    .sts_o  (sts),
    .words_o(ks_words)
  );

  assign s_axis_tready = !pend_q && !sts.busy && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_valid_q && m_axis_tready;
  assign ctr_eff       = s_axis_tuser ? init_ctr_q : blk_ctr_q;
  assign off_eff       = s_axis_tuser ? 6'd0 : off_q;
  assign need_blk      = (off_eff == 6'd0);
  assign start         = in_acc && need_blk;
  assign ks_byte       = ks_words[off_q[5:2]][{off_q[1:0], 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce_q    <= '0;
      init_ctr_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cc20_pkg::REG_KEY_01:   key_q[1:0] <= cfg_wdata_i;
        cc20_pkg::REG_KEY_23:   key_q[3:2] <= cfg_wdata_i;
        cc20_pkg::REG_KEY_45:   key_q[5:4] <= cfg_wdata_i;
        cc20_pkg::REG_KEY_67:   key_q[7:6] <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_01: nonce_q[1:0] <= cfg_wdata_i;
        cc20_pkg::REG_NONCE_2:  nonce_q[2] <= cfg_wdata_i[31:0];
        cc20_pkg::REG_INIT_CTR: init_ctr_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_ctr_q <= 32'd0;
      off_q     <= 6'd0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        off_q <= off_eff + 6'd1;
      end
      if (start) begin
        blk_ctr_q <= ctr_eff + 32'd1;
      end
      priority if (sts.done) begin
        pend_q <= 1'b0;
      end else if (start) begin
        pend_q <= 1'b1;
      end
      priority if (sts.done) begin
        m_valid_q <= 1'b1;
      end else if (in_acc && !need_blk) begin
        m_valid_q <= 1'b1;
      end else if (out_acc) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pend_msg_q  <= s_axis_tdata;
      pend_last_q <= s_axis_tlast;
    end
    priority if (sts.done) begin
      m_data_q <= pend_msg_q ^ ks_words[0][7:0];
      m_last_q <= pend_last_q;
    end else if (in_acc && !need_blk) begin
      m_data_q <= s_axis_tdata ^ ks_byte;
      m_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

### rtl/core/cc20_qr_unit.sv
// shared add, xor and rotate unit for one quarter-round step
module cc20_qr_unit (
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  logic [1:0]  step_i,
  output logic [31:0] sum_o,
  output logic [31:0] mix_o
);

  logic [31:0] t;

  assign sum_o = x_i + y_i;
  assign t     = z_i ^ sum_o;

  always_comb begin
    unique case (step_i)
      cc20_pkg::STEP_AB16: mix_o = {t[15:0], t[31:16]};
      cc20_pkg::STEP_CD12: mix_o = {t[19:0], t[31:20]};
      cc20_pkg::STEP_AB8:  mix_o = {t[23:0], t[31:24]};
      cc20_pkg::STEP_CD7:  mix_o = {t[24:0], t[31:25]};
    endcase
  end

endmodule

### rtl/core/cc20_core.sv
// block sequencer: rounds and feed-forward add over the shared unit
module cc20_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           ctr_i,
  input  cc20_pkg::cc20_cfg_t   cfg_i,
  output cc20_pkg::cc20_sts_t   sts_o,
  output cc20_pkg::cc20_words_t words_o
);

  localparam int unsigned DrW = $clog2(DOUBLE_ROUNDS);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_FINAL = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [1:0]            step_q, step_d;
  logic [1:0]            qr_q, qr_d;
  logic                  diag_q, diag_d;
  logic [DrW-1:0]        dr_q, dr_d;
  logic [3:0]            fin_q, fin_d;
  logic                  done_q, done_d;
  logic [31:0]           ctr_q, ctr_d;
  cc20_pkg::cc20_words_t words_q, words_d;
  cc20_pkg::cc20_words_t upd;
  logic [1:0]            kind;
  logic [31:0]           x, y, z, sum, mix;

  cc20_qr_unit u_qr (
    .x_i   (x),
    .y_i   (y),
    .z_i   (z),
    .step_i(step_q),
    .sum_o (sum),
    .mix_o (mix)
  );

  always_comb begin
    x = words_q[0];
    y = words_q[4];
    z = words_q[12];
    if (state_q == C_FINAL) begin
      y = cc20_pkg::init_word(cfg_i, ctr_q, fin_q);
    end else if (step_q[0]) begin
      x = words_q[8];
      y = words_q[12];
      z = words_q[4];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    qr_d    = qr_q;
    diag_d  = diag_q;
    dr_d    = dr_q;
    fin_d   = fin_q;
    done_d  = 1'b0;
    ctr_d   = ctr_q;
    words_d = words_q;
    upd     = words_q;
    kind    = cc20_pkg::PERM_ROT1;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          words_d = cc20_pkg::init_state(cfg_i, ctr_i);
          ctr_d   = ctr_i;
          step_d  = 2'd0;
          qr_d    = 2'd0;
          diag_d  = 1'b0;
          dr_d    = '0;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        if (step_q[0]) begin
          upd[8] = sum;
          upd[4] = mix;
        end else begin
          upd[0]  = sum;
          upd[12] = mix;
        end
        step_d = step_q + 2'd1;
        if (step_q == cc20_pkg::STEP_CD7) begin
          if (qr_q == 2'd3) begin
            kind = diag_q ? cc20_pkg::PERM_FROM_DIAG : cc20_pkg::PERM_TO_DIAG;
          end
          words_d = cc20_pkg::permute_rows(upd, kind);
          qr_d    = qr_q + 2'd1;
          if (qr_q == 2'd3) begin
            diag_d = !diag_q;
            if (diag_q) begin
              dr_d = dr_q + 1'b1;
              if (dr_q == DrW'(DOUBLE_ROUNDS - 1)) begin
                state_d = C_FINAL;
                fin_d   = 4'd0;
              end
            end
          end
        end else begin
          words_d = upd;
        end
      end
      C_FINAL: begin
        words_d = {sum, words_q[15:1]};
        fin_d   = fin_q + 4'd1;
        if (fin_q == 4'd15) begin
          state_d = C_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= 2'd0;
      qr_q    <= 2'd0;
      diag_q  <= 1'b0;
      dr_q    <= '0;
      fin_q   <= 4'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      qr_q    <= qr_d;
      diag_q  <= diag_d;
      dr_q    <= dr_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q   <= ctr_d;
    words_q <= words_d;
  end

  assign sts_o.busy = (state_q != C_IDLE);
  assign sts_o.done = done_q;
  assign words_o    = words_q;

endmodule

### rtl/core/cc20_checker.sv
// port-level checks on the chacha20 stream top, bound to it
module cc20_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // an input transaction never lands on an untaken result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result pending");

  // a first byte always starts a new block, so no result and no input next
  a_first_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
      !m_axis_tvalid && !s_axis_tready)
    else $error("first byte did not start a block");

endmodule

bind chacha20_ietf_stream_xor cc20_checker u_cc20_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

### dv/tb_chacha20_ietf_stream_xor.sv
// self-checking testbench for the chacha20 ietf byte stream xor core
module tb_chacha20_ietf_stream_xor;

  localparam int unsigned N_DOUBLE_ROUNDS = 10;
  localparam int unsigned CYCLE_LIMIT     = 2000000;
  localparam int unsigned RANDOM_BYTES    = 950;
  localparam int unsigned IDLE_PERCENT    = 11;
  localparam logic [3:0][31:0] CHACHA_CONST = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } xor_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = cc20_pkg::REG_KEY_01;
  logic [63:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // keystream predictor state
  logic [7:0][31:0]  key_w     = '0;
  logic [2:0][31:0]  nonce_w   = '0;
  logic [31:0]       ctr_start = '0;
  logic [31:0]       blk_ctr   = '0;
  logic [5:0]        ks_pos    = '0;
  logic [63:0][7:0]  ks_bytes  = '0;
  logic [15:0][31:0] mix_w     = '0;

  xor_result_t expected_q[$];
  xor_result_t want;

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned msg_count    = 0;
  int unsigned load_count   = 0;
  int unsigned wrap_count   = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_left    = 0;
  logic        no_idle      = 1'b0;

  chacha20_ietf_stream_xor #(
    .DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void refill_keystream();
    logic [15:0][31:0] seed;
    logic [31:0]       sum;
    for (int i = 0; i < 4; i++) seed[i] = CHACHA_CONST[i];
    for (int i = 0; i < 8; i++) seed[4 + i] = key_w[i];
    seed[12] = blk_ctr;
    for (int i = 0; i < 3; i++) seed[13 + i] = nonce_w[i];
    mix_w = seed;
    for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = mix_w[i] + seed[i];
      for (int k = 0; k < 4; k++) ks_bytes[4 * i + k] = sum[8 * k +: 8];
    end
  endfunction

  function automatic void predict_xor(input logic [7:0] b, input logic f, input logic l);
    xor_result_t res;
    if (f) begin
      blk_ctr = ctr_start;
      ks_pos  = '0;
    end
    if (ks_pos == 6'd0) begin
      refill_keystream();
      blk_ctr = blk_ctr + 32'd1;
      if (blk_ctr == 32'd0) wrap_count++;
    end
    res.data = b ^ ks_bytes[ks_pos];
    res.last = l;
    ks_pos   = ks_pos + 6'd1;
    expected_q.push_back(res);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: result_byte 0x%02h result_last %0b",
               m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("result_byte: expected 0x%02h, actual 0x%02h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("result_last: expected %0b, actual %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // receiver backpressure, with an occasional long hold
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= f;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_xor(b, f, l);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len, input logic with_first);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), with_first && (i == 0), i == len - 1);
    end
    msg_count++;
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      cc20_pkg::REG_KEY_01:   key_w[1:0] = v;
      cc20_pkg::REG_KEY_23:   key_w[3:2] = v;
      cc20_pkg::REG_KEY_45:   key_w[5:4] = v;
      cc20_pkg::REG_KEY_67:   key_w[7:6] = v;
      cc20_pkg::REG_NONCE_01: nonce_w[1:0] = v;
      cc20_pkg::REG_NONCE_2:  nonce_w[2] = v[31:0];
      cc20_pkg::REG_INIT_CTR: ctr_start = v[31:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [255:0] key, input logic [95:0] nonce,
                               input logic [31:0] ctr);
    write_reg(cc20_pkg::REG_KEY_01, key[63:0]);
    write_reg(cc20_pkg::REG_KEY_23, key[127:64]);
    write_reg(cc20_pkg::REG_KEY_45, key[191:128]);
    write_reg(cc20_pkg::REG_KEY_67, key[255:192]);
    write_reg(cc20_pkg::REG_NONCE_01, nonce[63:0]);
    write_reg(cc20_pkg::REG_NONCE_2, {32'h0, nonce[95:64]});
    write_reg(cc20_pkg::REG_INIT_CTR, {32'h0, ctr});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    load_count++;
  endtask

  // mode 0 all zeros, mode 1 all ones, otherwise random
  task automatic load_random_settings(input int unsigned mode);
    logic [255:0] key;
    logic [95:0]  nonce;
    logic [31:0]  ctr;
    for (int i = 0; i < 8; i++) key[32 * i +: 32] = $urandom;
    for (int i = 0; i < 3; i++) nonce[32 * i +: 32] = $urandom;
    ctr = $urandom;
    if (mode == 0) begin
      key = '0; nonce = '0; ctr = '0;
    end else if (mode == 1) begin
      key = '1; nonce = '1; ctr = '1;
    end
    load_settings(key, nonce, ctr);
  endtask

  task automatic test_stream_from_reset();
    // no first flag yet: counter starts at zero with the reset key
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    // after a last byte the keystream just continues
    send_byte(8'h5a, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_extreme_settings();
    load_settings('1, '1, 32'hffff_ffff);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'haa, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    settle();
    load_settings('0, '0, 32'h0);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b1);
    // restart in the middle of a message
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b1, 1'b1);
    msg_count += 8;
    settle();
  endtask

  task automatic test_counter_wrap();
    logic [255:0] key;
    logic [95:0]  nonce;
    for (int i = 0; i < 8; i++) key[32 * i +: 32] = $urandom;
    for (int i = 0; i < 3; i++) nonce[32 * i +: 32] = $urandom;
    load_settings(key, nonce, 32'hffff_ffff);
    send_message(140, 1'b1);
    settle();
  endtask

  task automatic test_quiet_stretch();
    load_random_settings(2);
    @(negedge clk_i);
    no_idle = 1'b1;
    @(posedge clk_i);
    send_message(150, 1'b1);
    settle();
    @(negedge clk_i);
    no_idle = 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_output_backpressure();
    load_random_settings(2);
    @(negedge clk_i);
    hold_req = 600;
    @(posedge clk_i);
    send_message(90, 1'b1);
    settle();
  endtask

  task automatic test_random_messages(input int unsigned target);
    int unsigned len;
    int unsigned pick;
    int unsigned since_load;
    logic        f;
    logic        l;
    since_load = 3;
    while (bytes_sent < target) begin
      if (since_load >= 3 && $urandom_range(3) == 0) begin
        settle();
        load_random_settings($urandom_range(5));
        since_load = 0;
      end
      pick = $urandom_range(9);
      if (pick < 4) len = $urandom_range(8, 1);
      else if (pick < 8) len = $urandom_range(70, 9);
      else len = $urandom_range(200, 65);
      pick = $urandom_range(99);
      for (int unsigned i = 0; i < len; i++) begin
        f = (i == 0) && (pick >= 8);
        l = (i == len - 1);
        // broken sequences: stray first or last flags inside a message
        if (pick >= 8 && pick < 12 && i != 0) l = $urandom_range(7) == 0;
        if (pick >= 12 && pick < 15 && i != 0) f = $urandom_range(15) == 0;
        send_byte(8'($urandom), f, l);
      end
      msg_count++;
      since_load++;
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stream_from_reset();
    test_extreme_settings();
    test_counter_wrap();
    test_quiet_stretch();
    test_output_backpressure();
    test_random_messages(RANDOM_BYTES);
    settle();
    $display("run covered %0d bytes in %0d messages under %0d register loads",
             bytes_sent, msg_count, load_count);
    $display("%0d results checked, %0d block counter wraps, %0d mismatches",
             results_seen, wrap_count, fail_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
